// File: hdl/hpq_pkg.sv
// Shared types, widths and codes for the binary max-heap priority queue.
package hpq_pkg;

    localparam int DEPTH_DEF         = 64;
    localparam int PAYLOAD_BYTES_DEF = 8;

    localparam int FUNC_W  = 2;
    localparam int PRIO_W  = 32;
    localparam int DATA_W  = 64;
    localparam int LEN_W   = 4;
    localparam int STAT_W  = 2;
    localparam int TOTAL_W = 7;
    localparam int CAP_W   = 7;

    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = APB_AW - 2;

    localparam logic [REG_IDX_W-1:0] REG_CAPACITY = REG_IDX_W'(0);
    localparam logic [CAP_W-1:0]     CAP_RESET    = CAP_W'(64);

    localparam logic [FUNC_W-1:0] FUNC_INSERT = FUNC_W'(0);
    localparam logic [FUNC_W-1:0] FUNC_POP    = FUNC_W'(1);
    localparam logic [FUNC_W-1:0] FUNC_PEEK   = FUNC_W'(2);

    localparam logic [STAT_W-1:0] STAT_OK    = STAT_W'(0);
    localparam logic [STAT_W-1:0] STAT_FULL  = STAT_W'(1);
    localparam logic [STAT_W-1:0] STAT_EMPTY = STAT_W'(2);

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [PRIO_W-1:0] priority_req;
        logic [DATA_W-1:0]        payload;
        logic [LEN_W-1:0]         payload_len;
        logic                     keep_data;
    } t_in_word;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [DATA_W-1:0]  out_payload;
        logic [LEN_W-1:0]   out_len;
        logic [TOTAL_W-1:0] entry_total;
    } t_out_word;

    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic [DATA_W-1:0]        payload;
        logic [LEN_W-1:0]         len;
    } t_entry;

endpackage

// File: hdl/binary_max_heap_queue.sv
// Binary max-heap priority queue top level with its configuration register.
// One word is worked at a time. Insert climbs from the new leaf toward the root; pop sifts
// the last entry down from the root unless it empties the queue. Both use the shared
// priority comparator and the registered heap memory reads. Peek reads the root, and errors
// and unused codes go straight to the output. Reset empties the queue and sets the limit
// to 64.
module binary_max_heap_queue #(
    parameter int DEPTH         = hpq_pkg::DEPTH_DEF,
    parameter int PAYLOAD_BYTES = hpq_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  hpq_pkg::t_in_word           i_in_word,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output hpq_pkg::t_out_word          o_out_word,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hpq_pkg::APB_AW-1:0]  paddr,
    input  logic [hpq_pkg::APB_DW-1:0]  pwdata,
    output logic [hpq_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    logic [hpq_pkg::CAP_W-1:0]     r_cap;
    logic [hpq_pkg::REG_IDX_W-1:0] reg_idx;
    logic                          cap_sel;

    assign reg_idx = paddr[hpq_pkg::APB_AW-1:2];
    assign cap_sel = (reg_idx == hpq_pkg::REG_CAPACITY);
    assign pready  = 1'b1;
    assign prdata  = cap_sel ? hpq_pkg::APB_DW'(r_cap) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= hpq_pkg::CAP_RESET;
        end else if (psel && penable && pwrite && cap_sel) begin
            r_cap <= pwdata[hpq_pkg::CAP_W-1:0];
        end
    end

    hpq_core #(
        .DEPTH         (DEPTH),
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cap       (r_cap)
    );

endmodule

// File: hdl/hpq_ram.sv
// Heap entry memory with one write port and two registered read ports.
module hpq_ram #(
    parameter int DEPTH = hpq_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int W     = $bits(hpq_pkg::t_entry)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [W-1:0]  o_rdata_a,
    output logic [W-1:0]  o_rdata_b
);

    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= mem[i_raddr_a];
        o_rdata_b <= mem[i_raddr_b];
    end

endmodule

// File: hdl/hpq_core.sv
// Heap sequencer: one shared priority comparator walks sift-up and sift-down.
module hpq_core #(
    parameter int DEPTH         = hpq_pkg::DEPTH_DEF,
    parameter int PAYLOAD_BYTES = hpq_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  hpq_pkg::t_in_word        i_in_word,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output hpq_pkg::t_out_word       o_out_word,
    input  logic [hpq_pkg::CAP_W-1:0] i_cap
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IW    = AW + 2;
    localparam int CW    = (CNT_W > hpq_pkg::CAP_W) ? CNT_W : hpq_pkg::CAP_W;
    localparam int EW    = $bits(hpq_pkg::t_entry);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROOT_RD,
        S_ROOT,
        S_SD_RD,
        S_SD_PICK,
        S_SD_SWAP,
        S_SU_RD,
        S_SU_CMP,
        S_OUT
    } t_state;

    t_state                        r_state, n_state;
    logic [CNT_W-1:0]              r_count, n_count;
    logic [AW-1:0]                 r_pos, n_pos;
    logic [AW-1:0]                 r_pick_idx, n_pick_idx;
    hpq_pkg::t_entry               r_item, n_item;
    hpq_pkg::t_entry               r_pick, n_pick;
    logic [hpq_pkg::FUNC_W-1:0]    r_func, n_func;
    logic                          r_keep, n_keep;
    hpq_pkg::t_out_word            r_res, n_res;
    hpq_pkg::t_out_word            r_out_word, n_out_word;
    logic                          r_out_valid, n_out_valid;

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    hpq_pkg::t_entry               ram_wdata;
    logic [AW-1:0]                 ram_raddr_a;
    logic [AW-1:0]                 ram_raddr_b;
    hpq_pkg::t_entry               ram_rdata_a;
    hpq_pkg::t_entry               ram_rdata_b;

    logic signed [hpq_pkg::PRIO_W-1:0] cmp_a;
    logic signed [hpq_pkg::PRIO_W-1:0] cmp_b;
    logic                          cmp_gt;

    logic [IW-1:0]                 left_w;
    logic [IW-1:0]                 right_w;
    logic [IW-1:0]                 cnt_w;
    logic                          has_left;
    logic                          has_right;
    logic [AW-1:0]                 parent;
    logic [AW-1:0]                 last_idx;
    logic                          full;
    logic [hpq_pkg::LEN_W-1:0]     len_sat;
    logic [hpq_pkg::DATA_W-1:0]    masked;

    hpq_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .W     (EW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (ram_rdata_a),
        .o_rdata_b (ram_rdata_b)
    );

    assign left_w    = {1'b0, r_pos, 1'b1};
    assign right_w   = left_w + IW'(1);
    assign cnt_w     = IW'(r_count);
    assign has_left  = left_w < cnt_w;
    assign has_right = right_w < cnt_w;
    assign parent    = (r_pos - AW'(1)) >> 1;
    assign last_idx  = AW'(r_count - CNT_W'(1));
    assign full      = (r_count == CNT_W'(DEPTH)) || (CW'(r_count) >= CW'(i_cap));

    assign len_sat = (i_in_word.payload_len > hpq_pkg::LEN_W'(PAYLOAD_BYTES)) ?
                     hpq_pkg::LEN_W'(PAYLOAD_BYTES) : i_in_word.payload_len;

    always_comb begin
        for (int k = 0; k < hpq_pkg::DATA_W / 8; k++) begin
            masked[8*k +: 8] = (hpq_pkg::LEN_W'(k) < len_sat) ?
                               i_in_word.payload[8*k +: 8] : 8'h00;
        end
    end

    always_comb begin
        case (r_state)
            S_SD_PICK: begin
                cmp_a = ram_rdata_a.prio;
                cmp_b = ram_rdata_b.prio;
            end
            S_SD_SWAP: begin
                cmp_a = r_pick.prio;
                cmp_b = r_item.prio;
            end
            default: begin
                cmp_a = r_item.prio;
                cmp_b = ram_rdata_a.prio;
            end
        endcase
    end

    assign cmp_gt = cmp_a > cmp_b;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_pick_idx  = r_pick_idx;
        n_item      = r_item;
        n_pick      = r_pick;
        n_func      = r_func;
        n_keep      = r_keep;
        n_res       = r_res;
        n_out_word  = r_out_word;
        n_out_valid = r_out_valid && !i_out_ready;
        ram_we      = 1'b0;
        ram_waddr   = r_pos;
        ram_wdata   = r_item;
        ram_raddr_a = '0;
        ram_raddr_b = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_func            = i_in_word.func;
                    n_keep            = i_in_word.keep_data;
                    n_res.status      = hpq_pkg::STAT_OK;
                    n_res.out_payload = '0;
                    n_res.out_len     = '0;
                    n_res.entry_total = '0;
                    n_state           = S_OUT;
                    if (i_in_word.func == hpq_pkg::FUNC_INSERT) begin
                        if (full) begin
                            n_res.status = hpq_pkg::STAT_FULL;
                        end else begin
                            n_item.prio    = i_in_word.priority_req;
                            n_item.payload = masked;
                            n_item.len     = len_sat;
                            n_pos          = AW'(r_count);
                            n_count        = r_count + CNT_W'(1);
                            n_state        = S_SU_RD;
                        end
                    end else if (i_in_word.func == hpq_pkg::FUNC_POP ||
                                 i_in_word.func == hpq_pkg::FUNC_PEEK) begin
                        if (r_count == '0) begin
                            n_res.status = hpq_pkg::STAT_EMPTY;
                        end else begin
                            n_state = S_ROOT_RD;
                        end
                    end
                end
            end
            S_ROOT_RD: begin
                ram_raddr_a = '0;
                ram_raddr_b = last_idx;
                n_state     = S_ROOT;
            end
            S_ROOT: begin
                if (r_func == hpq_pkg::FUNC_PEEK || r_keep) begin
                    n_res.out_payload = ram_rdata_a.payload;
                    n_res.out_len     = ram_rdata_a.len;
                end
                if (r_func == hpq_pkg::FUNC_PEEK) begin
                    n_state = S_OUT;
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_item  = ram_rdata_b;
                    n_pos   = '0;
                    n_state = (r_count == CNT_W'(1)) ? S_OUT : S_SD_RD;
                end
            end
            S_SD_RD: begin
                ram_raddr_a = left_w[AW-1:0];
                ram_raddr_b = right_w[AW-1:0];
                if (has_left) begin
                    n_state = S_SD_PICK;
                end else begin
                    ram_we  = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_SD_PICK: begin
                if (!has_right || cmp_gt) begin
                    n_pick     = ram_rdata_a;
                    n_pick_idx = left_w[AW-1:0];
                end else begin
                    n_pick     = ram_rdata_b;
                    n_pick_idx = right_w[AW-1:0];
                end
                n_state = S_SD_SWAP;
            end
            S_SD_SWAP: begin
                ram_we = 1'b1;
                if (cmp_gt) begin
                    ram_wdata = r_pick;
                    n_pos     = r_pick_idx;
                    n_state   = S_SD_RD;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_SU_RD: begin
                ram_raddr_a = parent;
                if (r_pos == '0) begin
                    ram_we  = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_state = S_SU_CMP;
                end
            end
            S_SU_CMP: begin
                ram_we = 1'b1;
                if (cmp_gt) begin
                    ram_wdata = ram_rdata_a;
                    n_pos     = parent;
                    n_state   = S_SU_RD;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_word             = r_res;
                    n_out_word.entry_total = hpq_pkg::TOTAL_W'(r_count);
                    n_out_valid            = 1'b1;
                    n_state                = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_pos      <= n_pos;
        r_pick_idx <= n_pick_idx;
        r_item     <= n_item;
        r_pick     <= n_pick;
        r_func     <= n_func;
        r_keep     <= n_keep;
        r_res      <= n_res;
        r_out_word <= n_out_word;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
